[rtl/core/lkvc_pkg.sv]
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [RANK_BITS-1:0] LAST_RANK = RANK_BITS'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } lkvc_state_e;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } lkvc_req_e;

  typedef struct packed {
    logic                  hit;
    logic [RANK_BITS-1:0]  hit_rank;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  free_seen;
  } lkvc_chain_t;

  typedef struct packed {
    logic                  cmp_en;
    logic                  upd_en;
    logic                  hit;
    logic                  is_put;
    logic                  any_free;
    logic [RANK_BITS-1:0]  hit_rank;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lkvc_cmd_t;

endpackage

[rtl/core/lkvc_cell.sv]
`timescale 1ns / 1ps

module lkvc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_pkg::lkvc_cmd_t   cmd_i,
  input  lkvc_pkg::lkvc_chain_t chain_i,
  output lkvc_pkg::lkvc_chain_t chain_o
);

  logic [lkvc_pkg::KEY_BITS-1:0]   key_q, key_d;
  logic [lkvc_pkg::VALUE_BITS-1:0] val_q, val_d;
  logic [lkvc_pkg::RANK_BITS-1:0]  rank_q, rank_d;
  logic                            valid_q, valid_d;
  logic                            match_q, match_d;
  logic                            free_q, free_d;
  logic                            lru_q, lru_d;
  logic                            match;
  logic                            victim;

  assign match = valid_q && (key_q == cmd_i.key);

  always_comb begin
    chain_o.hit       = chain_i.hit | match;
    chain_o.hit_rank  = chain_i.hit_rank | (match ? rank_q : '0);
    chain_o.hit_value = chain_i.hit_value | (match ? val_q : '0);
    chain_o.free_seen = chain_i.free_seen | ~valid_q;
  end

  assign victim = cmd_i.any_free ? free_q : lru_q;

  always_comb begin
    match_d = match_q;
    free_d  = free_q;
    lru_d   = lru_q;
    key_d   = key_q;
    val_d   = val_q;
    rank_d  = rank_q;
    valid_d = valid_q;
    if (cmd_i.cmp_en) begin
      match_d = match;
      free_d  = ~valid_q & ~chain_i.free_seen;
      lru_d   = valid_q && (rank_q == lkvc_pkg::LAST_RANK);
    end
    if (cmd_i.upd_en) begin
      if (cmd_i.hit) begin
        if (match_q) begin
          rank_d = '0;
          if (cmd_i.is_put) begin
            val_d = cmd_i.value;
          end
        end else if (valid_q && (rank_q < cmd_i.hit_rank)) begin
          rank_d = rank_q + 1'b1;
        end
      end else if (cmd_i.is_put) begin
        if (victim) begin
          key_d   = cmd_i.key;
          val_d   = cmd_i.value;
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      lru_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      match_q <= match_d;
      free_q  <= free_d;
      lru_q   <= lru_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

endmodule

[rtl/core/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// Fully associative key-value cache with strict LRU replacement, built as a row of
// identical cells, one per entry, each holding key, value, valid bit and recency rank.
// A get returns the stored value and hit on a match and makes the entry most recent;
// a put updates a present key or fills the lowest free cell, evicting the least recent
// entry when full; a put always returns a zero value. Each transaction runs as a
// compare cycle, in which the key is matched in every cell and the hit, rank, value
// and first free cell ripple down the row, followed by an update cycle, in which
// every cell ages or rewrites itself at once. The next request is taken in the update
// cycle, so a new request is accepted while the last one finishes. The result sits in
// an output register; while it waits unread the update cycle holds.

module lru_key_value_cache (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [lkvc_pkg::KEY_BITS-1:0]   key_i,
  input  logic [lkvc_pkg::VALUE_BITS-1:0] write_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            hit_o,
  output logic [lkvc_pkg::VALUE_BITS-1:0] read_value_o
);

  lkvc_pkg::lkvc_state_e state_q, state_d;

  logic                            put_q, put_d;
  logic [lkvc_pkg::KEY_BITS-1:0]   key_q, key_d;
  logic [lkvc_pkg::VALUE_BITS-1:0] wval_q, wval_d;

  logic                            hit_q, hit_d;
  logic [lkvc_pkg::RANK_BITS-1:0]  hrank_q, hrank_d;
  logic [lkvc_pkg::VALUE_BITS-1:0] hval_q, hval_d;
  logic                            free_q, free_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_hit_q, out_hit_d;
  logic [lkvc_pkg::VALUE_BITS-1:0] out_val_q, out_val_d;

  logic in_fire;
  logic go;
  logic cmp_en;
  logic upd_en;

  lkvc_pkg::lkvc_cmd_t   cmd;
  lkvc_pkg::lkvc_chain_t chain [lkvc_pkg::ENTRIES+1];

  assign in_fire = in_valid_i && in_ready_o;
  assign go      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_fire) state_d = lkvc_pkg::ST_CMP;
      end
      lkvc_pkg::ST_CMP: begin
        state_d = lkvc_pkg::ST_UPD;
      end
      lkvc_pkg::ST_UPD: begin
        if (go) state_d = in_fire ? lkvc_pkg::ST_CMP : lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmp_en     = 1'b0;
    upd_en     = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: in_ready_o = 1'b1;
      lkvc_pkg::ST_CMP:  cmp_en = 1'b1;
      lkvc_pkg::ST_UPD: begin
        in_ready_o = go;
        upd_en     = go;
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.cmp_en   = cmp_en;
    cmd.upd_en   = upd_en;
    cmd.hit      = hit_q;
    cmd.is_put   = put_q;
    cmd.any_free = free_q;
    cmd.hit_rank = hrank_q;
    cmd.key      = key_q;
    cmd.value    = wval_q;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < lkvc_pkg::ENTRIES; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .chain_i (chain[g]),
      .chain_o (chain[g+1])
    );
  end

  always_comb begin
    put_d  = put_q;
    key_d  = key_q;
    wval_d = wval_q;
    if (in_fire) begin
      put_d  = (req_type_i == lkvc_pkg::REQ_PUT);
      key_d  = key_i;
      wval_d = write_value_i;
    end
  end

  always_comb begin
    hit_d   = hit_q;
    hrank_d = hrank_q;
    hval_d  = hval_q;
    free_d  = free_q;
    if (cmp_en) begin
      hit_d   = chain[lkvc_pkg::ENTRIES].hit;
      hrank_d = chain[lkvc_pkg::ENTRIES].hit_rank;
      hval_d  = chain[lkvc_pkg::ENTRIES].hit_value;
      free_d  = chain[lkvc_pkg::ENTRIES].free_seen;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_hit_d   = out_hit_q;
    out_val_d   = out_val_q;
    if (upd_en) begin
      out_valid_d = 1'b1;
      out_hit_d   = hit_q;
      out_val_d   = (hit_q && !put_q) ? hval_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkvc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    put_q     <= put_d;
    key_q     <= key_d;
    wval_q    <= wval_d;
    hit_q     <= hit_d;
    hrank_q   <= hrank_d;
    hval_q    <= hval_d;
    free_q    <= free_d;
    out_hit_q <= out_hit_d;
    out_val_q <= out_val_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_val_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned POOL_MAX    = 32;

  typedef struct packed {
    logic                            hit;
    logic [lkvc_pkg::VALUE_BITS-1:0] value;
  } cache_resp_t;

  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  lkvc_pkg::lkvc_req_e             req_type    = lkvc_pkg::REQ_GET;
  logic [lkvc_pkg::KEY_BITS-1:0]   req_key     = '0;
  logic [lkvc_pkg::VALUE_BITS-1:0] write_value = '0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic                            hit;
  logic [lkvc_pkg::VALUE_BITS-1:0] read_value;

  logic [lkvc_pkg::KEY_BITS-1:0]   cell_key   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VALUE_BITS-1:0] cell_value [lkvc_pkg::ENTRIES];
  logic                            cell_valid [lkvc_pkg::ENTRIES] = '{default: 1'b0};
  logic [lkvc_pkg::RANK_BITS-1:0]  cell_rank  [lkvc_pkg::ENTRIES] = '{default: '0};
  int unsigned                     fill_count = 0;

  cache_resp_t                     pending_responses[$];
  logic [lkvc_pkg::KEY_BITS-1:0]   key_pool[POOL_MAX];

  bit          send_idle  = 1'b0;
  bit          recv_idle  = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned hit_count = 0;
  int unsigned evict_count = 0;

  lru_key_value_cache u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .key_i         (req_key),
    .write_value_i (write_value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .hit_o         (hit),
    .read_value_o  (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb: timeout after %0d cycles, %0d responses outstanding", cycle_count,
                 pending_responses.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic void cache_lookup(input lkvc_pkg::lkvc_req_e req,
                                       input logic [lkvc_pkg::KEY_BITS-1:0] k,
                                       input logic [lkvc_pkg::VALUE_BITS-1:0] v,
                                       output cache_resp_t resp);
    int                             found;
    int                             slot;
    logic [lkvc_pkg::RANK_BITS-1:0] old_rank;
    logic [lkvc_pkg::RANK_BITS-1:0] top_rank;
    found = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (found < 0 && cell_valid[i] && cell_key[i] == k) found = i;
    end
    resp.hit   = (found >= 0);
    resp.value = '0;
    if (found >= 0) begin
      hit_count++;
      old_rank = cell_rank[found];
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (cell_valid[i] && cell_rank[i] < old_rank) cell_rank[i]++;
      end
      cell_rank[found] = '0;
      if (req == lkvc_pkg::REQ_PUT) begin
        cell_value[found] = v;
      end else begin
        resp.value = cell_value[found];
      end
    end else if (req == lkvc_pkg::REQ_PUT) begin
      slot = -1;
      if (fill_count < lkvc_pkg::ENTRIES) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (slot < 0 && !cell_valid[i]) slot = i;
        end
      end
      if (slot < 0) begin
        top_rank = '0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (cell_valid[i] && (slot < 0 || cell_rank[i] > top_rank)) begin
            slot     = i;
            top_rank = cell_rank[i];
          end
        end
        cell_valid[slot] = 1'b0;
        evict_count++;
      end else begin
        fill_count++;
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        if (cell_valid[i]) cell_rank[i]++;
      end
      cell_key[slot]   = k;
      cell_value[slot] = v;
      cell_valid[slot] = 1'b1;
      cell_rank[slot]  = '0;
    end
  endfunction

  task automatic send_request(input lkvc_pkg::lkvc_req_e req,
                              input logic [lkvc_pkg::KEY_BITS-1:0] k,
                              input logic [lkvc_pkg::VALUE_BITS-1:0] v);
    int unsigned gap;
    cache_resp_t resp;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    req_key     <= k;
    write_value <= v;
    do @(negedge clk); while (!in_ready);
    cache_lookup(req, k, v, resp);
    pending_responses.push_back(resp);
    @(posedge clk);
    sent_count++;
  endtask

  initial begin : response_sink
    int unsigned gap;
    cache_resp_t want;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 13) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("tb: unexpected response hit=%0b value=%h", hit, read_value);
      end else begin
        want = pending_responses.pop_front();
        checked_count++;
        if (hit !== want.hit || read_value !== want.value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("tb: response %0d mismatch: expected hit=%0b value=%h, got hit=%0b value=%h",
                     checked_count, want.hit, want.value, hit, read_value);
        end
      end
      @(posedge clk);
    end
  end

  task automatic test_empty_cache();
    send_request(lkvc_pkg::REQ_GET, '0, '1);
    send_request(lkvc_pkg::REQ_GET, '1, '0);
  endtask

  task automatic test_extreme_fields();
    send_request(lkvc_pkg::REQ_PUT, '0, '1);
    send_request(lkvc_pkg::REQ_PUT, '1, '0);
    send_request(lkvc_pkg::REQ_GET, '0, '0);
    send_request(lkvc_pkg::REQ_GET, '1, '1);
    send_request(lkvc_pkg::REQ_PUT, '0, 32'h5a5a_a5a5);
    send_request(lkvc_pkg::REQ_GET, '0, '1);
  endtask

  task automatic test_fill_and_evict();
    for (int i = 0; i < lkvc_pkg::ENTRIES - 2; i++)
      send_request(lkvc_pkg::REQ_PUT, lkvc_pkg::KEY_BITS'(32'h100 + i), $urandom);
    send_request(lkvc_pkg::REQ_GET, '0, $urandom);
    send_request(lkvc_pkg::REQ_PUT, 32'hdead_beef, $urandom);
    send_request(lkvc_pkg::REQ_GET, '1, $urandom);
    send_request(lkvc_pkg::REQ_GET, '0, $urandom);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned pool_size);
    lkvc_pkg::lkvc_req_e           req;
    logic [lkvc_pkg::KEY_BITS-1:0] k;
    for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      req = lkvc_pkg::lkvc_req_e'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = $urandom;
      send_request(req, k, $urandom);
    end
  endtask

  task automatic test_backpressure();
    send_idle   = 1'b0;
    recv_idle   = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    for (int n = 0; n < 50; n++)
      send_request(lkvc_pkg::lkvc_req_e'($urandom_range(0, 1)),
                   key_pool[$urandom_range(0, 7)], $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_cache();
    test_extreme_fields();
    test_fill_and_evict();
    test_random_traffic(320, 12);
    test_backpressure();
    test_random_traffic(320, 20);
    test_random_traffic(320, 17);
    test_random_traffic(320, 28);

    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d requests, %0d responses checked, %0d hits, %0d evictions",
             sent_count, checked_count, hit_count, evict_count);
    $display("tb: %0d mismatches over %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache.sv
sim/testbench.sv
